// File: rtl/core/tles_pkg.sv
`default_nettype none

package tles_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_WIDTH  = 4'd0,
      CSR_MAX_HEIGHT = 4'd1
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] LIMIT_RESET = 16'd32;

   // edge that gets bisected
   typedef enum logic [1:0] {
      EDGE_AB = 2'd0,
      EDGE_BC = 2'd1,
      EDGE_AC = 2'd2
   } edge_sel_type;

   // control travelling with a triangle into the result sequencer
   typedef struct packed {
      logic split;
      logic batch_last;
   } tri_ctrl_type;

   // flags shown with each result item
   typedef struct packed {
      logic split;
      logic last;
      logic batch_end;
   } rsp_flag_type;

endpackage

`default_nettype wire

// File: rtl/core/tles_out_seq.sv
`default_nettype none

module tles_out_seq #(
   parameter int COORD_WIDTH = 24
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                in_valid,
   output logic                               in_ready,
   input  wire tles_pkg::tri_ctrl_type        in_ctrl,
   input  wire logic signed [COORD_WIDTH-1:0] in_p_x,
   input  wire logic signed [COORD_WIDTH-1:0] in_p_y,
   input  wire logic signed [COORD_WIDTH-1:0] in_q_x,
   input  wire logic signed [COORD_WIDTH-1:0] in_q_y,
   input  wire logic signed [COORD_WIDTH-1:0] in_r_x,
   input  wire logic signed [COORD_WIDTH-1:0] in_r_y,
   input  wire logic signed [COORD_WIDTH-1:0] in_m_x,
   input  wire logic signed [COORD_WIDTH-1:0] in_m_y,
   output logic                               out_valid,
   input  wire                                out_ready,
   output tles_pkg::rsp_flag_type             out_flag,
   output logic signed [COORD_WIDTH-1:0]      out_x0,
   output logic signed [COORD_WIDTH-1:0]      out_y0,
   output logic signed [COORD_WIDTH-1:0]      out_x1,
   output logic signed [COORD_WIDTH-1:0]      out_y1,
   output logic signed [COORD_WIDTH-1:0]      out_x2,
   output logic signed [COORD_WIDTH-1:0]      out_y2
);
   import tles_pkg::*;

   logic                          valid_ff, valid_in;
   logic                          phase_ff, phase_in;
   tri_ctrl_type                  ctrl_ff;
   logic signed [COORD_WIDTH-1:0] p_x_ff, p_y_ff, q_x_ff, q_y_ff;
   logic signed [COORD_WIDTH-1:0] r_x_ff, r_y_ff, m_x_ff, m_y_ff;
   logic                          last;
   logic                          fire;
   logic                          load;

   // a split triangle gives two items, the first vertex switching from P to Q
   assign last     = !ctrl_ff.split || phase_ff;
   assign fire     = valid_ff && out_ready;
   assign in_ready = !valid_ff || (out_ready && last);
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (load) begin
         valid_in = 1'b1;
         phase_in = 1'b0;
      end else if (fire) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   // triangle held while its items drain
   always_ff @(posedge clock) begin
      if (load) begin
         ctrl_ff <= in_ctrl;
         p_x_ff  <= in_p_x;
         p_y_ff  <= in_p_y;
         q_x_ff  <= in_q_x;
         q_y_ff  <= in_q_y;
         r_x_ff  <= in_r_x;
         r_y_ff  <= in_r_y;
         m_x_ff  <= in_m_x;
         m_y_ff  <= in_m_y;
      end
   end

   assign out_valid          = valid_ff;
   assign out_flag.split     = ctrl_ff.split;
   assign out_flag.last      = last;
   assign out_flag.batch_end = last && ctrl_ff.batch_last;
   assign out_x0             = phase_ff ? q_x_ff : p_x_ff;
   assign out_y0             = phase_ff ? q_y_ff : p_y_ff;
   assign out_x1             = r_x_ff;
   assign out_y1             = r_y_ff;
   assign out_x2             = m_x_ff;
   assign out_y2             = m_y_ff;

endmodule

`default_nettype wire

// File: rtl/core/triangle_longest_edge_splitter.sv
// Path: the accepting edge loads stage 1; the triangle then passes three more stages and
// the result register before its first result item is offered.
// Throughput: one triangle per cycle if unsplit and rsp_ready is high; a split one holds
// the result register while both items drain, the single port giving one item per cycle.
// Reset (synchronous): all valid bits clear, both limits return to 32 pixels.
`default_nettype none

module triangle_longest_edge_splitter #(
   parameter int COORD_WIDTH = 24,
   parameter int FRAC_BITS   = 8
) (
   input  wire                                     clock,
   input  wire                                     reset,
   // input triangles
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire logic signed [COORD_WIDTH-1:0]      req_ax,
   input  wire logic signed [COORD_WIDTH-1:0]      req_ay,
   input  wire logic signed [COORD_WIDTH-1:0]      req_bx,
   input  wire logic signed [COORD_WIDTH-1:0]      req_by,
   input  wire logic signed [COORD_WIDTH-1:0]      req_cx,
   input  wire logic signed [COORD_WIDTH-1:0]      req_cy,
   input  wire                                     req_batch_last_in,
   // result triangles
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic signed [COORD_WIDTH-1:0]           rsp_out_ax,
   output logic signed [COORD_WIDTH-1:0]           rsp_out_ay,
   output logic signed [COORD_WIDTH-1:0]           rsp_out_bx,
   output logic signed [COORD_WIDTH-1:0]           rsp_out_by,
   output logic signed [COORD_WIDTH-1:0]           rsp_out_cx,
   output logic signed [COORD_WIDTH-1:0]           rsp_out_cy,
   output logic                                    rsp_needs_more_split,
   output logic                                    rsp_last_of_item,
   output logic                                    rsp_batch_end,
   // configuration
   input  wire                                     csr_we,
   input  wire logic [tles_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [tles_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tles_pkg::*;

   localparam int W     = COORD_WIDTH;
   localparam int LIM_W = CSR_DATA_W + FRAC_BITS;
   localparam int CMP_W = (W > LIM_W) ? W : LIM_W;
   localparam int SQ_W  = 2 * W;
   localparam int LEN_W = SQ_W + 1;

   typedef logic signed [W-1:0] coord_type;
   typedef logic signed [W:0]   diff_type;
   typedef logic [W-1:0]        span_type;
   typedef logic [SQ_W-1:0]     sq_type;
   typedef logic [LEN_W-1:0]    len_type;

   // coordinate order: ax, ay, bx, by, cx, cy
   // span/midpoint order: AB x, AB y, BC x, BC y, AC x, AC y

   // ------------------------------------------------------------------
   // limit registers
   logic [CSR_DATA_W-1:0] max_width_ff, max_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_width_ff  <= LIMIT_RESET;
         max_height_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_WIDTH:  max_width_ff  <= csr_wdata;
            CSR_MAX_HEIGHT: max_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // stage handshake: a stage loads when empty or when its item moves on
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic en1, en2, en3, en4;
   logic seq_ready;

   assign en4       = !s4_valid_ff || seq_ready;
   assign en3       = !s3_valid_ff || en4;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: edge differences and midpoints
   coord_type crd_in [6];
   diff_type  s1_diff_in [6];
   coord_type s1_mid_in [6];
   coord_type s1_crd_ff [6];
   diff_type  s1_diff_ff [6];
   coord_type s1_mid_ff [6];
   logic      s1_bl_ff;

   diff_type  sum_in [6];

   assign crd_in[0] = req_ax;
   assign crd_in[1] = req_ay;
   assign crd_in[2] = req_bx;
   assign crd_in[3] = req_by;
   assign crd_in[4] = req_cx;
   assign crd_in[5] = req_cy;

   always_comb begin
      // AB, then BC, then AC; x and y each
      s1_diff_in[0] = diff_type'(crd_in[0]) - diff_type'(crd_in[2]);
      s1_diff_in[1] = diff_type'(crd_in[1]) - diff_type'(crd_in[3]);
      s1_diff_in[2] = diff_type'(crd_in[2]) - diff_type'(crd_in[4]);
      s1_diff_in[3] = diff_type'(crd_in[3]) - diff_type'(crd_in[5]);
      s1_diff_in[4] = diff_type'(crd_in[0]) - diff_type'(crd_in[4]);
      s1_diff_in[5] = diff_type'(crd_in[1]) - diff_type'(crd_in[5]);
      sum_in[0]     = diff_type'(crd_in[0]) + diff_type'(crd_in[2]);
      sum_in[1]     = diff_type'(crd_in[1]) + diff_type'(crd_in[3]);
      sum_in[2]     = diff_type'(crd_in[2]) + diff_type'(crd_in[4]);
      sum_in[3]     = diff_type'(crd_in[3]) + diff_type'(crd_in[5]);
      sum_in[4]     = diff_type'(crd_in[0]) + diff_type'(crd_in[4]);
      sum_in[5]     = diff_type'(crd_in[1]) + diff_type'(crd_in[5]);
      // dropping the low bit of the sum is a floor halving
      for (int k = 0; k < 6; k++) begin
         s1_mid_in[k] = sum_in[k][W:1];
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_crd_ff  <= crd_in;
         s1_diff_ff <= s1_diff_in;
         s1_mid_ff  <= s1_mid_in;
         s1_bl_ff   <= req_batch_last_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: absolute spans and the limit check
   span_type           s2_span_in [6];
   logic               s2_over_in;
   logic [CMP_W-1:0]   lim_x, lim_y;
   span_type           s2_span_ff [6];
   logic               s2_over_ff;
   coord_type          s2_crd_ff [6];
   coord_type          s2_mid_ff [6];
   logic               s2_bl_ff;

   assign lim_x = CMP_W'(max_width_ff) << FRAC_BITS;
   assign lim_y = CMP_W'(max_height_ff) << FRAC_BITS;

   always_comb begin
      s2_over_in = 1'b0;
      for (int k = 0; k < 6; k++) begin
         // |diff| < 2^W always, so the low W bits hold it
         s2_span_in[k] = s1_diff_ff[k][W] ? span_type'(-s1_diff_ff[k])
                                          : span_type'(s1_diff_ff[k]);
         if (k % 2 == 0) begin
            if (CMP_W'(s2_span_in[k]) > lim_x) s2_over_in = 1'b1;
         end else begin
            if (CMP_W'(s2_span_in[k]) > lim_y) s2_over_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_span_ff <= s2_span_in;
         s2_over_ff <= s2_over_in;
         s2_crd_ff  <= s1_crd_ff;
         s2_mid_ff  <= s1_mid_ff;
         s2_bl_ff   <= s1_bl_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: squared spans
   sq_type    s3_sq_in [6];
   sq_type    s3_sq_ff [6];
   logic      s3_over_ff;
   coord_type s3_crd_ff [6];
   coord_type s3_mid_ff [6];
   logic      s3_bl_ff;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         s3_sq_in[k] = sq_type'(s2_span_ff[k]) * sq_type'(s2_span_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_sq_ff   <= s3_sq_in;
         s3_over_ff <= s2_over_ff;
         s3_crd_ff  <= s2_crd_ff;
         s3_mid_ff  <= s2_mid_ff;
         s3_bl_ff   <= s2_bl_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: squared edge lengths
   len_type   s4_len_in [3];
   len_type   s4_len_ff [3];
   logic      s4_over_ff;
   coord_type s4_crd_ff [6];
   coord_type s4_mid_ff [6];
   logic      s4_bl_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s4_len_in[k] = len_type'(s3_sq_ff[2*k]) + len_type'(s3_sq_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_len_ff  <= s4_len_in;
         s4_over_ff <= s3_over_ff;
         s4_crd_ff  <= s3_crd_ff;
         s4_mid_ff  <= s3_mid_ff;
         s4_bl_ff   <= s3_bl_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: longest edge and vertex rotation, into the result register
   edge_sel_type edge_sel;
   tri_ctrl_type seq_ctrl;
   coord_type    p_x, p_y, q_x, q_y, r_x, r_y, m_x, m_y;

   // strict compares: ties go to BC or AC, never AB
   always_comb begin
      if (s4_len_ff[0] > s4_len_ff[1]) begin
         edge_sel = (s4_len_ff[0] > s4_len_ff[2]) ? EDGE_AB : EDGE_AC;
      end else begin
         edge_sel = (s4_len_ff[1] > s4_len_ff[2]) ? EDGE_BC : EDGE_AC;
      end
   end

   always_comb begin
      // unchanged triangle: A, B, C with a single item
      p_x = s4_crd_ff[0];
      p_y = s4_crd_ff[1];
      q_x = s4_crd_ff[0];
      q_y = s4_crd_ff[1];
      r_x = s4_crd_ff[2];
      r_y = s4_crd_ff[3];
      m_x = s4_crd_ff[4];
      m_y = s4_crd_ff[5];
      if (s4_over_ff) begin
         case (edge_sel)
            EDGE_AB: begin
               q_x = s4_crd_ff[2];
               q_y = s4_crd_ff[3];
               r_x = s4_crd_ff[4];
               r_y = s4_crd_ff[5];
               m_x = s4_mid_ff[0];
               m_y = s4_mid_ff[1];
            end
            EDGE_BC: begin
               p_x = s4_crd_ff[2];
               p_y = s4_crd_ff[3];
               q_x = s4_crd_ff[4];
               q_y = s4_crd_ff[5];
               r_x = s4_crd_ff[0];
               r_y = s4_crd_ff[1];
               m_x = s4_mid_ff[2];
               m_y = s4_mid_ff[3];
            end
            default: begin
               q_x = s4_crd_ff[4];
               q_y = s4_crd_ff[5];
               r_x = s4_crd_ff[2];
               r_y = s4_crd_ff[3];
               m_x = s4_mid_ff[4];
               m_y = s4_mid_ff[5];
            end
         endcase
      end
   end

   assign seq_ctrl.split      = s4_over_ff;
   assign seq_ctrl.batch_last = s4_bl_ff;

   rsp_flag_type rsp_flag;

   tles_out_seq #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_out_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid_ff),
      .in_ready  (seq_ready),
      .in_ctrl   (seq_ctrl),
      .in_p_x    (p_x),
      .in_p_y    (p_y),
      .in_q_x    (q_x),
      .in_q_y    (q_y),
      .in_r_x    (r_x),
      .in_r_y    (r_y),
      .in_m_x    (m_x),
      .in_m_y    (m_y),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_flag  (rsp_flag),
      .out_x0    (rsp_out_ax),
      .out_y0    (rsp_out_ay),
      .out_x1    (rsp_out_bx),
      .out_y1    (rsp_out_by),
      .out_x2    (rsp_out_cx),
      .out_y2    (rsp_out_cy)
   );

   assign rsp_needs_more_split = rsp_flag.split;
   assign rsp_last_of_item     = rsp_flag.last;
   assign rsp_batch_end        = rsp_flag.batch_end;

   // ------------------------------------------------------------------
   // checks

   // a triangle passed unchanged is always a single item
   a_unsplit_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_needs_more_split |-> rsp_last_of_item)
      else $error("unsplit triangle not marked last");

   // batch end only on the final item of a triangle
   a_batch_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_batch_end |-> rsp_last_of_item)
      else $error("batch end on a non-final item");

   // first half of a split is followed by its second half
   a_second_half: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_item |=>
         rsp_valid && rsp_needs_more_split && rsp_last_of_item)
      else $error("second half of split missing");

   // both halves share the opposite vertex and the midpoint
   a_shared_vertices: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_item |=>
         $stable(rsp_out_bx) && $stable(rsp_out_by) &&
         $stable(rsp_out_cx) && $stable(rsp_out_cy))
      else $error("split halves disagree on shared vertices");

endmodule

`default_nettype wire
